### hw/rtl/tic_pkg.sv
`timescale 1ns / 1ps

package tic_pkg;

    // sizes
    localparam int LEVELS        = 4;
    localparam int LEVEL_REGS    = 4;
    localparam int LANES         = (LEVELS < LEVEL_REGS) ? LEVELS : LEVEL_REGS;
    localparam int COORD_BITS    = 16;
    localparam int VALUE_BITS    = 16;
    localparam int PROD_BITS     = VALUE_BITS + COORD_BITS;
    localparam int DIV_STEPS     = COORD_BITS;
    localparam int PIPE_DEPTH    = DIV_STEPS + 4;
    localparam int LI_BITS       = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int OUT_LVL_BITS  = 2;
    localparam int CNT_BITS      = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LEVEL_COUNT = 3'd0,
        CFG_LEVEL_0     = 3'd1,
        CFG_LEVEL_1     = 3'd2,
        CFG_LEVEL_2     = 3'd3,
        CFG_LEVEL_3     = 3'd4
    } t_cfg_idx;

    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef t_coord [2:0]                 t_vec;

    typedef struct packed {
        t_value [2:0] val;
        t_vec   [2:0] pos;
    } t_tri;

    typedef struct packed {
        t_vec p0;
        t_vec p1;
    } t_seg;

    typedef struct packed {
        t_seg                    seg;
        logic [OUT_LVL_BITS-1:0] level_index;
        logic                    last;
    } t_out;

endpackage

### hw/rtl/tic_if.sv
`timescale 1ns / 1ps

// triangle request channel
interface tic_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [tic_pkg::VALUE_BITS-1:0] value_a;
    logic signed [tic_pkg::VALUE_BITS-1:0] value_b;
    logic signed [tic_pkg::VALUE_BITS-1:0] value_c;
    logic signed [tic_pkg::COORD_BITS-1:0] a_x;
    logic signed [tic_pkg::COORD_BITS-1:0] a_y;
    logic signed [tic_pkg::COORD_BITS-1:0] a_z;
    logic signed [tic_pkg::COORD_BITS-1:0] b_x;
    logic signed [tic_pkg::COORD_BITS-1:0] b_y;
    logic signed [tic_pkg::COORD_BITS-1:0] b_z;
    logic signed [tic_pkg::COORD_BITS-1:0] c_x;
    logic signed [tic_pkg::COORD_BITS-1:0] c_y;
    logic signed [tic_pkg::COORD_BITS-1:0] c_z;

    modport source (
        output valid, value_a, value_b, value_c,
        output a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
        input  ready
    );
    modport sink (
        input  valid, value_a, value_b, value_c,
        input  a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
        output ready
    );
endinterface

// segment request channel
interface tic_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [tic_pkg::COORD_BITS-1:0]   start_x;
    logic signed [tic_pkg::COORD_BITS-1:0]   start_y;
    logic signed [tic_pkg::COORD_BITS-1:0]   start_z;
    logic signed [tic_pkg::COORD_BITS-1:0]   end_x;
    logic signed [tic_pkg::COORD_BITS-1:0]   end_y;
    logic signed [tic_pkg::COORD_BITS-1:0]   end_z;
    logic        [tic_pkg::OUT_LVL_BITS-1:0] level_index;
    logic                                    last;

    modport source (
        output valid, start_x, start_y, start_z, end_x, end_y, end_z,
        output level_index, last,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
        input  level_index, last,
        output ready
    );
endinterface

### hw/rtl/triangle_isocontour_segments_unit.sv
`timescale 1ns / 1ps

// channel   | dir | payload                                         | request moves
// ----------+-----+-------------------------------------------------+------------------
// i_tri     | in  | value_a..c, a_x..c_z                            | one triangle
// o_seg     | out | start_x..z, end_x..z, level_index, last         | one segment
// i_cfg_*   | in  | level_count, level_0..level_3 by index          | one register write
//
// each enabled level has its own lane; every lane runs a pipelined divider per edge coordinate
// a triangle can enter every cycle while the pipeline is not stalled
// the merge stage sends one segment per cycle while o_seg is ready, so a triangle with several
// segments holds it until its last segment is sent
// the whole pipeline stalls together while its tail waits on the merge stage
// synchronous active-low reset clears the pipeline valids, the merge stage and the registers
module triangle_isocontour_segments_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    tic_in_if.sink                                i_tri,
    tic_out_if.source                             o_seg,
    input  logic                                  i_cfg_we,
    input  logic [tic_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [tic_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);

    localparam int NL = tic_pkg::LANES;
    localparam int PD = tic_pkg::PIPE_DEPTH;

    logic [tic_pkg::CNT_BITS-1:0]         r_level_count;
    tic_pkg::t_value                      r_level [tic_pkg::LEVEL_REGS];
    logic [PD-1:0]                        r_vld;
    tic_pkg::t_tri                        r_tri;

    logic                                 w_adv;
    logic                                 w_in_acc;
    logic                                 w_mrg_ready;
    logic [NL-1:0]                        w_hit;
    logic [NL-1:0]                        w_mask;
    tic_pkg::t_seg [NL-1:0]               w_seg;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_count <= tic_pkg::CNT_BITS'(1);
            for (int i = 0; i < tic_pkg::LEVEL_REGS; i++) begin
                r_level[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (tic_pkg::t_cfg_idx'(i_cfg_idx))
                tic_pkg::CFG_LEVEL_COUNT: begin
                    r_level_count <= i_cfg_data[tic_pkg::CNT_BITS-1:0];
                end
                tic_pkg::CFG_LEVEL_0: begin
                    r_level[0] <= i_cfg_data;
                end
                tic_pkg::CFG_LEVEL_1: begin
                    r_level[1] <= i_cfg_data;
                end
                tic_pkg::CFG_LEVEL_2: begin
                    r_level[2] <= i_cfg_data;
                end
                tic_pkg::CFG_LEVEL_3: begin
                    r_level[3] <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // pipeline advance
    assign w_adv       = !r_vld[PD-1] || w_mrg_ready;
    assign i_tri.ready = w_adv;
    assign w_in_acc    = i_tri.valid && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PD-2:0], w_in_acc};
        end
    end

    // triangle input register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tri.val[0]    <= i_tri.value_a;
            r_tri.val[1]    <= i_tri.value_b;
            r_tri.val[2]    <= i_tri.value_c;
            r_tri.pos[0][0] <= i_tri.a_x;
            r_tri.pos[0][1] <= i_tri.a_y;
            r_tri.pos[0][2] <= i_tri.a_z;
            r_tri.pos[1][0] <= i_tri.b_x;
            r_tri.pos[1][1] <= i_tri.b_y;
            r_tri.pos[1][2] <= i_tri.b_z;
            r_tri.pos[2][0] <= i_tri.c_x;
            r_tri.pos[2][1] <= i_tri.c_y;
            r_tri.pos[2][2] <= i_tri.c_z;
        end
    end

    // one lane per level
    for (genvar li = 0; li < NL; li++) begin : g_lane
        tic_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_adv),
            .i_tri   (r_tri),
            .i_level (r_level[li]),
            .o_hit   (w_hit[li]),
            .o_seg   (w_seg[li])
        );
        assign w_mask[li] = w_hit[li] && (r_level_count > tic_pkg::CNT_BITS'(li));
    end

    tic_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[PD-1]),
        .o_ready (w_mrg_ready),
        .i_mask  (w_mask),
        .i_seg   (w_seg),
        .o_seg   (o_seg)
    );

endmodule

### hw/rtl/tic_div.sv
`timescale 1ns / 1ps

// pipelined restoring divider, one quotient bit per stage
// the quotient is known to fit in COORD_BITS bits
module tic_div (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [tic_pkg::PROD_BITS-1:0]    i_num,
    input  logic [tic_pkg::VALUE_BITS-1:0]   i_den,
    output logic [tic_pkg::COORD_BITS-1:0]   o_quo
);

    localparam int VB = tic_pkg::VALUE_BITS;
    localparam int CB = tic_pkg::COORD_BITS;
    localparam int NS = tic_pkg::DIV_STEPS;

    logic [VB-1:0] r_rem [NS];
    logic [CB-1:0] r_lo  [NS];
    logic [VB-1:0] r_den [NS];
    logic [CB-1:0] r_q   [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [VB-1:0] w_rem;
        logic [CB-1:0] w_lo;
        logic [VB-1:0] w_den;
        logic [CB-1:0] w_q;
        logic [VB:0]   w_trial;
        logic [VB:0]   w_diff;
        logic          w_ge;

        if (s == 0) begin : g_first
            assign w_rem = i_num[tic_pkg::PROD_BITS-1:CB];
            assign w_lo  = i_num[CB-1:0];
            assign w_den = i_den;
            assign w_q   = '0;
        end else begin : g_next
            assign w_rem = r_rem[s-1];
            assign w_lo  = r_lo[s-1];
            assign w_den = r_den[s-1];
            assign w_q   = r_q[s-1];
        end

        // shift in next numerator bit and trial subtract
        assign w_trial = {w_rem, w_lo[CB-1-s]};
        assign w_diff  = w_trial - {1'b0, w_den};
        assign w_ge    = (w_trial >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? w_diff[VB-1:0] : w_trial[VB-1:0];
                r_lo[s]  <= w_lo;
                r_den[s] <= w_den;
                r_q[s]   <= {w_q[CB-2:0], w_ge};
            end
        end
    end

    assign o_quo = r_q[NS-1];

endmodule

### hw/rtl/tic_lane.sv
`timescale 1ns / 1ps

// one iso level: tests every triangle edge and forms the segment
module tic_lane (
    input  logic                i_clk,
    input  logic                i_en,
    input  tic_pkg::t_tri       i_tri,
    input  tic_pkg::t_value     i_level,
    output logic                o_hit,
    output tic_pkg::t_seg       o_seg
);

    localparam int VB = tic_pkg::VALUE_BITS;
    localparam int CB = tic_pkg::COORD_BITS;
    localparam int PB = tic_pkg::PROD_BITS;
    localparam int NS = tic_pkg::DIV_STEPS;

    wire [2:0]                w_cross;
    wire [2:0][2:0][CB-1:0]   w_pt;

    logic                     r_hit;
    tic_pkg::t_seg            r_seg;

    for (genvar e = 0; e < 3; e++) begin : g_edge
        localparam int F = (e + 1) % 3;

        logic                   w_swap;
        tic_pkg::t_value        w_lo_v;
        tic_pkg::t_value        w_hi_v;
        tic_pkg::t_vec          w_plo;
        tic_pkg::t_vec          w_phi;
        logic [VB:0]            w_d;
        logic [VB:0]            w_t;
        logic                   w_cr;

        logic                   r_cross1;
        logic [VB-1:0]          r_d1;
        logic [VB-1:0]          r_t1;
        logic [2:0][CB-1:0]     r_mag1;
        logic [2:0]             r_neg1;
        tic_pkg::t_vec          r_plo1;

        logic                   r_cross2;
        logic [VB-1:0]          r_d2;
        logic [2:0][PB-1:0]     r_num2;
        logic [2:0]             r_neg2;
        tic_pkg::t_vec          r_plo2;

        logic                   r_sc_cross [NS];
        logic [2:0]             r_sc_neg   [NS];
        tic_pkg::t_vec          r_sc_plo   [NS];

        wire [2:0][CB-1:0]      w_quo;
        wire [2:0][CB-1:0]      w_mag;
        wire [2:0]              w_neg;

        // order the edge ends by value, the first-named end is the low end on a tie
        assign w_swap = $signed(i_tri.val[e]) > $signed(i_tri.val[F]);
        assign w_lo_v = w_swap ? i_tri.val[F] : i_tri.val[e];
        assign w_hi_v = w_swap ? i_tri.val[e] : i_tri.val[F];
        assign w_plo  = w_swap ? i_tri.pos[F] : i_tri.pos[e];
        assign w_phi  = w_swap ? i_tri.pos[e] : i_tri.pos[F];
        assign w_cr   = ($signed(i_level) >= $signed(w_lo_v))
                     && ($signed(i_level) <  $signed(w_hi_v));
        assign w_d    = {w_hi_v[VB-1], w_hi_v} - {w_lo_v[VB-1], w_lo_v};
        assign w_t    = {i_level[VB-1], i_level} - {w_lo_v[VB-1], w_lo_v};

        // coordinate spans as sign and magnitude
        for (genvar k = 0; k < 3; k++) begin : g_span
            logic [CB:0] w_dk;
            logic [CB:0] w_ak;
            assign w_dk     = {w_phi[k][CB-1], w_phi[k]} - {w_plo[k][CB-1], w_plo[k]};
            assign w_ak     = w_dk[CB] ? (~w_dk + 1'b1) : w_dk;
            assign w_neg[k] = w_dk[CB];
            assign w_mag[k] = w_ak[CB-1:0];
        end

        // edge set-up stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cross1 <= w_cr;
                r_d1     <= w_d[VB-1:0];
                r_t1     <= w_t[VB-1:0];
                r_mag1   <= w_mag;
                r_neg1   <= w_neg;
                r_plo1   <= w_plo;
            end
        end

        // span times level offset
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int k = 0; k < 3; k++) begin
                    r_num2[k] <= PB'(r_mag1[k]) * PB'(r_t1);
                end
                r_cross2 <= r_cross1;
                r_d2     <= r_d1;
                r_neg2   <= r_neg1;
                r_plo2   <= r_plo1;
            end
        end

        for (genvar k = 0; k < 3; k++) begin : g_div
            tic_div u_div (
                .i_clk (i_clk),
                .i_en  (i_en),
                .i_num (r_num2[k]),
                .i_den (r_d2),
                .o_quo (w_quo[k])
            );
        end

        // side data follows the divider
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sc_cross[0] <= r_cross2;
                r_sc_neg[0]   <= r_neg2;
                r_sc_plo[0]   <= r_plo2;
                for (int s = 1; s < NS; s++) begin
                    r_sc_cross[s] <= r_sc_cross[s-1];
                    r_sc_neg[s]   <= r_sc_neg[s-1];
                    r_sc_plo[s]   <= r_sc_plo[s-1];
                end
            end
        end

        // crossing point: start plus signed quotient
        for (genvar k = 0; k < 3; k++) begin : g_pt
            logic [CB:0] w_q;
            logic [CB:0] w_sum;
            assign w_q        = r_sc_neg[NS-1][k] ? (~{1'b0, w_quo[k]} + 1'b1)
                                                  : {1'b0, w_quo[k]};
            assign w_sum      = {r_sc_plo[NS-1][k][CB-1], r_sc_plo[NS-1][k]} + w_q;
            assign w_pt[e][k] = w_sum[CB-1:0];
        end

        assign w_cross[e] = r_sc_cross[NS-1];
    end

    // keep a segment only for exactly two crossings, in edge order
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= (w_cross == 3'b011) || (w_cross == 3'b101) || (w_cross == 3'b110);
            if (w_cross[0]) begin
                r_seg.p0 <= w_pt[0];
                r_seg.p1 <= w_cross[1] ? w_pt[1] : w_pt[2];
            end else begin
                r_seg.p0 <= w_pt[1];
                r_seg.p1 <= w_pt[2];
            end
        end
    end

    assign o_hit = r_hit;
    assign o_seg = r_seg;

endmodule

### hw/rtl/tic_merge.sv
`timescale 1ns / 1ps

// collects the lane results of one triangle and sends them in level order
module tic_merge (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_vld,
    output logic                                     o_ready,
    input  logic [tic_pkg::LANES-1:0]                i_mask,
    input  tic_pkg::t_seg [tic_pkg::LANES-1:0]       i_seg,
    tic_out_if.source                                o_seg
);

    localparam int NL = tic_pkg::LANES;

    logic [NL-1:0]                    r_pend;
    tic_pkg::t_seg [NL-1:0]           r_segs;
    logic                             r_ovld;
    tic_pkg::t_out                    r_out;

    logic                             w_out_free;
    logic                             w_pend_one;
    logic                             w_emit;
    logic                             w_take;
    logic [tic_pkg::LI_BITS-1:0]      w_pick;
    logic [NL-1:0]                    w_pick_mask;

    // lowest pending level
    always_comb begin
        w_pick = '0;
        for (int i = NL - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                w_pick = tic_pkg::LI_BITS'(i);
            end
        end
    end

    assign w_pick_mask = NL'(1) << w_pick;
    assign w_out_free  = !r_ovld || o_seg.ready;
    assign w_pend_one  = (r_pend != '0) && ((r_pend & (r_pend - 1'b1)) == '0);
    assign w_emit      = w_out_free && (r_pend != '0);
    assign o_ready     = (r_pend == '0) || (w_out_free && w_pend_one);
    assign w_take      = i_vld && o_ready;

    // pending levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (w_take) begin
            r_pend <= i_mask;
        end else if (w_emit) begin
            r_pend <= r_pend & ~w_pick_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_segs <= i_seg;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_out_free) begin
            r_ovld <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.seg         <= r_segs[w_pick];
            r_out.level_index <= tic_pkg::OUT_LVL_BITS'(w_pick);
            r_out.last        <= (r_pend & ~w_pick_mask) == '0;
        end
    end

    assign o_seg.valid       = r_ovld;
    assign o_seg.start_x     = r_out.seg.p0[0];
    assign o_seg.start_y     = r_out.seg.p0[1];
    assign o_seg.start_z     = r_out.seg.p0[2];
    assign o_seg.end_x       = r_out.seg.p1[0];
    assign o_seg.end_y       = r_out.seg.p1[1];
    assign o_seg.end_z       = r_out.seg.p1[2];
    assign o_seg.level_index = r_out.level_index;
    assign o_seg.last        = r_out.last;

    // a segment that is not the last leaves more behind it
    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && !r_out.last |-> r_pend != '0)
        else $error("non-final segment with nothing pending");

    // the single remaining level is sent as the last one
    a_last_on_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit && w_pend_one |=> r_ovld && r_out.last)
        else $error("last flag missing on final segment");

    // a new triangle loads its level mask
    a_take_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_pend == $past(i_mask))
        else $error("pending mask not loaded");

endmodule

### verif/tic_tb_if.sv
`timescale 1ns / 1ps

// plain write port driven by the test bench
interface tic_cfg_port_if;
    logic                                  we;
    logic [tic_pkg::CFG_IDX_BITS-1:0]      idx;
    logic [tic_pkg::CFG_DATA_BITS-1:0]     data;

    modport source (output we, idx, data);
    modport sink (input we, idx, data);
endinterface

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int N_RANDOM       = 320;

    typedef struct {
        logic signed [15:0] val [3];
        logic signed [15:0] pos [3][3];
    } t_tb_tri;

    typedef struct {
        logic signed [15:0] sx, sy, sz, ex, ey, ez;
        logic [1:0]         lvl;
        logic               last;
    } t_tb_seg;

    // directed row: triangle plus optional typed-in answer for the first segment
    typedef struct {
        t_tb_tri shape;
        int      n_typed;
        t_tb_seg typed;
    } t_tb_row;

    logic i_clk;
    logic i_rst_n;

    tic_in_if       tri_ch ();
    tic_out_if      seg_ch ();
    tic_cfg_port_if cfg_port ();

    triangle_isocontour_segments_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tri      (tri_ch),
        .o_seg      (seg_ch),
        .i_cfg_we   (cfg_port.we),
        .i_cfg_idx  (cfg_port.idx),
        .i_cfg_data (cfg_port.data)
    );

    // predictor copy of the registers
    logic [2:0]         lvl_count;
    logic signed [15:0] lvl_val [4];

    t_tb_seg expected_segs [$];
    int   mismatches;
    int   idle_cycles;
    bit   quiet_phase;
    bit   sink_done;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // interpolate one edge; returns 1 on crossing
    function automatic bit edge_point(input logic signed [15:0] lvl,
                                      input logic signed [15:0] v0, v1,
                                      input logic signed [15:0] p0 [3], p1 [3],
                                      output logic signed [15:0] pt [3]);
        longint lo, hi, num;
        logic signed [15:0] plo [3];
        logic signed [15:0] phi [3];
        lo = v0; hi = v1; plo = p0; phi = p1;
        if (v0 > v1) begin
            lo = v1; hi = v0; plo = p1; phi = p0;
        end
        pt = '{16'sd0, 16'sd0, 16'sd0};
        if (!(lvl < hi && lvl >= lo))
            return 1'b0;
        for (int k = 0; k < 3; k++) begin
            num = (longint'(phi[k]) - longint'(plo[k])) * (longint'(lvl) - lo);
            pt[k] = 16'(longint'(plo[k]) + num / (hi - lo));
        end
        return 1'b1;
    endfunction

    // segments of one triangle over all enabled levels
    function automatic void predict_segments(input t_tb_tri t);
        int   n, hits, f, first_idx;
        logic signed [15:0] pts [2][3];
        logic signed [15:0] pt [3];
        t_tb_seg s;
        n = (lvl_count > 4) ? 4 : lvl_count;
        first_idx = expected_segs.size();
        for (int li = 0; li < n; li++) begin
            hits = 0;
            for (int e = 0; e < 3; e++) begin
                f = (e + 1) % 3;
                if (edge_point(lvl_val[li], t.val[e], t.val[f], t.pos[e], t.pos[f], pt)) begin
                    if (hits < 2) pts[hits] = pt;
                    hits++;
                end
            end
            if (hits == 2) begin
                s.sx = pts[0][0]; s.sy = pts[0][1]; s.sz = pts[0][2];
                s.ex = pts[1][0]; s.ey = pts[1][1]; s.ez = pts[1][2];
                s.lvl = 2'(li);
                s.last = 1'b0;
                expected_segs.insert(expected_segs.size(), s);
            end
        end
        if (expected_segs.size() > first_idx)
            expected_segs[expected_segs.size() - 1].last = 1'b1;
    endfunction

    task automatic write_reg(input tic_pkg::t_cfg_idx idx, input logic [15:0] data);
        cfg_port.we   <= 1'b1;
        cfg_port.idx  <= idx;
        cfg_port.data <= data;
        @(negedge i_clk);
        cfg_port.we <= 1'b0;
        case (idx)
            tic_pkg::CFG_LEVEL_COUNT: lvl_count = data[2:0];
            tic_pkg::CFG_LEVEL_0:     lvl_val[0] = data;
            tic_pkg::CFG_LEVEL_1:     lvl_val[1] = data;
            tic_pkg::CFG_LEVEL_2:     lvl_val[2] = data;
            tic_pkg::CFG_LEVEL_3:     lvl_val[3] = data;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // wait until all segments have come, then let the pipeline empty
    task automatic settle();
        tri_ch.valid <= 1'b0;
        while (expected_segs.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // send one triangle, outside the quiet phase sometimes with a random gap before it
    task automatic send_triangle(input t_tb_tri t);
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            tri_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        tri_ch.valid   <= 1'b1;
        tri_ch.value_a <= t.val[0];
        tri_ch.value_b <= t.val[1];
        tri_ch.value_c <= t.val[2];
        tri_ch.a_x <= t.pos[0][0]; tri_ch.a_y <= t.pos[0][1]; tri_ch.a_z <= t.pos[0][2];
        tri_ch.b_x <= t.pos[1][0]; tri_ch.b_y <= t.pos[1][1]; tri_ch.b_z <= t.pos[1][2];
        tri_ch.c_x <= t.pos[2][0]; tri_ch.c_y <= t.pos[2][1]; tri_ch.c_z <= t.pos[2][2];
        @(posedge i_clk);
        while (!tri_ch.ready) @(posedge i_clk);
        predict_segments(t);
        @(negedge i_clk);
    endtask

    function automatic t_tb_tri make_tri(input int v0, v1, v2, input int c);
        t_tb_tri t;
        t.val = '{16'(v0), 16'(v1), 16'(v2)};
        for (int v = 0; v < 3; v++)
            for (int k = 0; k < 3; k++)
                t.pos[v][k] = 16'(c * (v + 1) * (k + 1));
        return t;
    endfunction

    // random triangle: mostly values straddling the levels, some full range, some at the extremes
    function automatic t_tb_tri random_tri();
        t_tb_tri t;
        int   mode;
        mode = $urandom_range(0, 9);
        for (int v = 0; v < 3; v++) begin
            if (mode < 6)
                t.val[v] = 16'(int'(lvl_val[$urandom_range(0, 3)])
                               + $signed($urandom_range(0, 400)) - 200);
            else if (mode < 8)
                t.val[v] = 16'($urandom);
            else
                t.val[v] = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            for (int k = 0; k < 3; k++)
                t.pos[v][k] = (mode == 9) ? ($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000)
                                          : 16'($urandom);
        end
        return t;
    endfunction

    // result checking and output stalls
    initial begin
        t_tb_seg exp_s;
        mismatches  = 0;
        idle_cycles = 0;
        seg_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && seg_ch.valid && seg_ch.ready) begin
                if (expected_segs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected segment level %0d", seg_ch.level_index);
                end else begin
                    exp_s = expected_segs.pop_front();
                    if (seg_ch.start_x !== exp_s.sx || seg_ch.start_y !== exp_s.sy ||
                        seg_ch.start_z !== exp_s.sz || seg_ch.end_x !== exp_s.ex ||
                        seg_ch.end_y !== exp_s.ey || seg_ch.end_z !== exp_s.ez ||
                        seg_ch.level_index !== exp_s.lvl || seg_ch.last !== exp_s.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("segment mismatch: exp %0d %0d %0d -> %0d %0d %0d l%0d t%0d got %0d %0d %0d -> %0d %0d %0d l%0d t%0d",
                                exp_s.sx, exp_s.sy, exp_s.sz, exp_s.ex, exp_s.ey, exp_s.ez,
                                exp_s.lvl, exp_s.last, seg_ch.start_x, seg_ch.start_y,
                                seg_ch.start_z, seg_ch.end_x, seg_ch.end_y, seg_ch.end_z,
                                seg_ch.level_index, seg_ch.last);
                    end
                end
            end
            // watchdog on requests in either direction
            if ((tri_ch.valid && tri_ch.ready) || (seg_ch.valid && seg_ch.ready) || sink_done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
            @(negedge i_clk);
            if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                seg_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
            end else begin
                seg_ch.ready <= 1'b1;
            end
        end
    end

    // stimulus
    initial begin
        t_tb_row rows [$];
        t_tb_row r;
        t_tb_tri t;
        int   n_before;
        tri_ch.valid = 1'b0;
        {tri_ch.value_a, tri_ch.value_b, tri_ch.value_c} = '0;
        {tri_ch.a_x, tri_ch.a_y, tri_ch.a_z, tri_ch.b_x, tri_ch.b_y, tri_ch.b_z} = '0;
        {tri_ch.c_x, tri_ch.c_y, tri_ch.c_z} = '0;
        cfg_port.we = 1'b0; cfg_port.idx = '0; cfg_port.data = '0;
        quiet_phase = 1'b0;
        sink_done = 1'b0;
        lvl_count = 3'd1;
        lvl_val = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
        i_rst_n = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // after reset: one level at 0; a=-4 b=4 c=-4 crosses a-b and b-c at midpoints
        r.n_typed = 1;
        r.shape = make_tri(-4, 4, -4, 0);
        r.shape.pos[0] = '{16'sd0, 16'sd0, 16'sd0};
        r.shape.pos[1] = '{16'sd8, 16'sd8, 16'sd8};
        r.shape.pos[2] = '{16'sd0, 16'sd16, 16'sd0};
        r.typed = '{16'sd4, 16'sd4, 16'sd4, 16'sd4, 16'sd12, 16'sd4, 2'd0, 1'b1};
        rows.insert(rows.size(), r);
        r.n_typed = 0;
        // vertices a and b sit on the level: each starts its rising edge, the flat edge a-b gives no crossing
        r.shape = make_tri(0, 0, 5, 3);
        rows.insert(rows.size(), r);
        // equal values everywhere
        r.shape = make_tri(0, 0, 0, 7);
        rows.insert(rows.size(), r);
        r.shape = make_tri(-5, -5, -5, 7);
        rows.insert(rows.size(), r);
        // value extremes with coordinate extremes, then further value extremes and small values
        t = make_tri(-32768, 32767, -32768, 0);
        t.pos[0] = '{16'sh8000, 16'sh7fff, 16'sh8000};
        t.pos[1] = '{16'sh7fff, 16'sh8000, 16'sh7fff};
        t.pos[2] = '{16'sh7fff, 16'sh7fff, 16'sh8000};
        r.shape = t;
        rows.insert(rows.size(), r);
        r.shape = make_tri(32767, -32768, 0, -1000);
        rows.insert(rows.size(), r);
        r.shape = make_tri(0, -1, 1, 9000);
        rows.insert(rows.size(), r);
        r.shape = make_tri(1, 1, -1, -3);
        rows.insert(rows.size(), r);

        foreach (rows[i]) begin
            n_before = expected_segs.size();
            send_triangle(rows[i].shape);
            if (rows[i].n_typed > 0 && expected_segs.size() > n_before)
                expected_segs[n_before] = rows[i].typed;
        end
        settle();

        // four levels, extremes and a level count over the limit
        write_reg(tic_pkg::CFG_LEVEL_COUNT, 16'd7);
        write_reg(tic_pkg::CFG_LEVEL_0, 16'sh8000);
        write_reg(tic_pkg::CFG_LEVEL_1, 16'sh7fff);
        write_reg(tic_pkg::CFG_LEVEL_2, 16'sd0);
        write_reg(tic_pkg::CFG_LEVEL_3, 16'sh7ffe);
        rows.delete();
        r.shape = make_tri(-32768, 32767, 0, 11);
        rows.insert(rows.size(), r);
        r.shape = make_tri(32767, -32768, 32767, -11);
        rows.insert(rows.size(), r);
        r.shape = make_tri(-32768, -32768, 32767, 5);
        rows.insert(rows.size(), r);
        r.shape = make_tri(0, 32767, -32768, 1234);
        rows.insert(rows.size(), r);
        foreach (rows[i]) send_triangle(rows[i].shape);
        settle();

        // level count zero
        write_reg(tic_pkg::CFG_LEVEL_COUNT, 16'd0);
        send_triangle(make_tri(-32768, 32767, 0, 3));
        settle();

        // random phases over several settings
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(tic_pkg::CFG_LEVEL_COUNT, 16'($urandom_range(1, 7)));
            write_reg(tic_pkg::CFG_LEVEL_0, 16'($urandom));
            write_reg(tic_pkg::CFG_LEVEL_1, 16'($signed($urandom_range(0, 2000)) - 1000));
            write_reg(tic_pkg::CFG_LEVEL_2, 16'($urandom));
            write_reg(tic_pkg::CFG_LEVEL_3, 16'($signed($urandom_range(0, 200)) - 100));
            if (ph == 3) quiet_phase = 1'b1;
            for (int i = 0; i < N_RANDOM / 4; i++)
                send_triangle(random_tri());
            if (ph < 3) settle();
        end

        // finish
        tri_ch.valid <= 1'b0;
        while (expected_segs.size() != 0) @(negedge i_clk);
        sink_done = 1'b1;
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && expected_segs.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
